// ===== rtl/spms_pkg.sv =====
package spms_pkg;

    localparam int NUM_STACKS = 8;
    localparam int NUM_SLOTS  = 64;

    localparam int DATA_W  = 32;
    localparam int NUM_W   = 4;
    localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int STACK_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int DEPTH_W = $clog2(NUM_SLOTS + 1);

    // free-slot search runs in groups of eight used bits
    localparam int GROUP      = 8;
    localparam int GROUP_W    = 3;
    localparam int NUM_GROUPS = (NUM_SLOTS + GROUP - 1) / GROUP;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [SLOT_W-1:0] below;
    } t_slot;

endpackage

// ===== rtl/shared_pool_multi_stack.sv =====
// A transaction is latched on accept, and its result is registered into the result register
// when the execute state fires.
// A new transaction is taken only in the idle state, so the block finishes one before it takes
// the next; the slot memory is read in the accept cycle and written back in the execute cycle.
// A stalled master side holds the block in the execute cycle until the result register frees.
// Reset (i_rst_n low, synchronous) clears the used bits and stack depths at once; no clearing
// pass, the slot memory and top pointers are left as they are.
module shared_pool_multi_stack (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [31:0] push_value
    input  logic [spms_pkg::DATA_W-1:0]    i_s_axis_tdata,
    // [0] operation, [4:1] stack_number
    input  logic [spms_pkg::NUM_W:0]       i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [31:0] popped_value
    output logic [spms_pkg::DATA_W-1:0]    o_m_axis_tdata,
    // [0] push_accepted, [1] pop_empty
    output logic [1:0]                     o_m_axis_tuser
);

    import spms_pkg::*;

    // Control
    t_state r_state, n_state;
    logic   accept;
    logic   out_free;
    logic   fire;

    // Pool state: slot memory, used bits, per-stack top pointer and depth
    t_slot               r_mem [NUM_SLOTS];
    t_slot               r_rd;
    logic [NUM_SLOTS-1:0] r_used, n_used;
    logic [SLOT_W-1:0]   r_top   [NUM_STACKS];
    logic [DEPTH_W-1:0]  r_depth [NUM_STACKS];

    // Transaction held between accept and execute
    t_op                 r_op;
    logic                r_hit;
    logic [STACK_W-1:0]  r_idx;
    logic [DATA_W-1:0]   r_value;
    logic [SLOT_W-1:0]   r_free;
    logic                r_free_ok;

    // Result register
    logic                r_out_valid;
    logic                r_out_accepted;
    logic                r_out_empty;
    logic [DATA_W-1:0]   r_out_value;

    // Input decode
    t_op                 in_op;
    logic [NUM_W-1:0]    in_num;
    logic                in_hit;
    logic [STACK_W-1:0]  in_idx;

    // Free-slot search
    logic [NUM_GROUPS-1:0] grp_any;
    logic [GROUP_W-1:0]    grp_low [NUM_GROUPS];
    logic [SLOT_W-1:0]     free_slot;
    logic                  free_ok;

    // Execute
    logic [DEPTH_W-1:0]  cur_depth;
    logic [SLOT_W-1:0]   cur_top;
    logic                do_push;
    logic                do_pop;

    assign in_op  = t_op'(i_s_axis_tuser[0]);
    assign in_num = i_s_axis_tuser[NUM_W:1];
    assign in_hit = (in_num != '0) && (int'(in_num) <= NUM_STACKS);
    // out-of-range stacks index entry zero; the hit flag stops any update
    assign in_idx = in_hit ? STACK_W'(in_num - 4'd1) : '0;

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign fire     = (r_state == ST_EXEC) && out_free;

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold here while the result register is still occupied
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Lowest free slot: first the lowest free bit inside each group of eight, then the
    // lowest group that has one. Bits past the end of the pool count as used.
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_any[g] = 1'b0;
            grp_low[g] = '0;
            for (int b = GROUP - 1; b >= 0; b--) begin
                if ((g * GROUP + b) < NUM_SLOTS) begin
                    if (!r_used[SLOT_W'(g * GROUP + b)]) begin
                        grp_any[g] = 1'b1;
                        grp_low[g] = GROUP_W'(b);
                    end
                end
            end
        end
        free_ok   = 1'b0;
        free_slot = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
            if (grp_any[g]) begin
                free_ok   = 1'b1;
                free_slot = SLOT_W'(g * GROUP + int'(grp_low[g]));
            end
        end
    end

    // Latch the transaction; the free slot is taken now, the used bits do not move until
    // the execute cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= in_op;
            r_hit     <= in_hit;
            r_idx     <= in_idx;
            r_value   <= i_s_axis_tdata;
            r_free    <= free_slot;
            r_free_ok <= free_ok;
        end
    end

    assign cur_depth = r_depth[r_idx];
    assign cur_top   = r_top[r_idx];
    assign do_push   = fire && (r_op == OP_PUSH) && r_hit && r_free_ok;
    assign do_pop    = fire && (r_op == OP_POP) && r_hit && (cur_depth != '0);

    // Slot memory: read the addressed stack's top on accept, write a pushed slot on execute.
    // The read data holds through a stalled execute cycle.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_free] <= '{data: r_value, below: cur_top};
        end
        if (accept) begin
            r_rd <= r_mem[r_top[in_idx]];
        end
    end

    always_comb begin
        n_used = r_used;
        if (do_push) begin
            n_used[r_free] = 1'b1;
        end
        if (do_pop) begin
            n_used[cur_top] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            for (int k = 0; k < NUM_STACKS; k++) begin
                r_depth[k] <= '0;
            end
        end else begin
            r_used <= n_used;
            if (do_push) begin
                r_depth[r_idx] <= cur_depth + DEPTH_W'(1);
            end else if (do_pop) begin
                r_depth[r_idx] <= cur_depth - DEPTH_W'(1);
            end
        end
    end

    // Top pointer: advance to the new slot on push, drop to the slot below on pop unless
    // the stack runs empty.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_top[r_idx] <= r_free;
        end else if (do_pop && (cur_depth != DEPTH_W'(1))) begin
            r_top[r_idx] <= r_rd.below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_accepted <= do_push;
            r_out_empty    <= (r_op == OP_POP) && !do_pop;
            r_out_value    <= do_pop ? r_rd.data : ALL_ONES;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = {r_out_empty, r_out_accepted};

endmodule
